// ----- src/shfd_pkg.sv -----
// Package for the sync-header frame deframer: constants, register indexes
// and the result record type shared by the deframer RTL.
// Depends on nothing.
`default_nettype none

package shfd_pkg;

    // Sync pair that opens every frame.
    localparam logic [7:0] SYNC_FIRST  = 8'h55;
    localparam logic [7:0] SYNC_SECOND = 8'hAA;

    // Payload bytes whose index reaches this value are flagged as overflow.
    localparam int unsigned MAX_DATA = 64;

    // Largest number of destination ID bytes; larger settings act as this.
    localparam logic [2:0] MAX_ID_BYTES = 3'd4;

    // Configuration register indexes.
    localparam int CFG_INDEX_W = 2;
    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_ID_BYTES     = 2'd0,
        CFG_DEFAULT_DEST = 2'd1,
        CFG_DEFAULT_ORIG = 2'd2,
        CFG_UNUSED       = 2'd3
    } cfg_index_t;

    // Output stream packing.
    localparam int TDATA_W = 96;
    localparam int TUSER_W = 2;

    // One result as it sits in the output or skid register.
    typedef struct packed {
        logic [31:0] src_id;
        logic [31:0] dst_id;
        logic [7:0]  payload_length;
        logic [7:0]  byte_index;
        logic [7:0]  payload_byte;
        logic        byte_valid;
        logic        overflow;
        logic        last;
    } result_t;

endpackage

`default_nettype wire

// ----- src/sync_header_frame_deframer.sv -----
// Top level of the sync-header frame deframer: byte parser, output register
// and skid register. Depends on shfd_pkg for constants and the result type.
`default_nettype none

// Usage
// The slave stream (s_tvalid/s_tready/s_tdata) carries received bytes, one
// request per byte. The parser hunts for the sync pair 0x55 0xAA, gathers
// id_bytes destination ID bytes (most significant first), takes a length
// byte and then emits one result per payload byte on the master stream.
// A frame with a zero length gives a single empty result (byte_valid low).
// m_tlast marks the final result of a frame; m_tuser carries byte_valid and
// the overflow flag, set when a payload byte index is at or beyond MAX_DATA.
// A result is registered into the output register at the edge that accepts
// its byte, or into the skid register if the receiver stalls. Throughput is
// one byte per cycle while the skid register is empty. When the receiver
// stalls, one extra result is caught in the skid register and s_tready then
// drops until the output drains; s_tready depends only on that register, so
// no combinational path runs from m_tready. Configuration is written through
// cfg_wr_en/cfg_index/cfg_wdata while the stream is idle; the user is bound
// to this and the block does not enforce it. Reset returns the parser to the
// hunt, empties both output registers, sets id_bytes to 4, default IDs to 0.

module sync_header_frame_deframer #(
    parameter int unsigned MAX_DATA = shfd_pkg::MAX_DATA
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    // Configuration write port.
    input  wire logic                                cfg_wr_en,
    input  wire logic [shfd_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  wire logic [31:0]                         cfg_wdata,
    // Received byte stream.
    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    input  wire logic [7:0]                          s_tdata,  // [7:0] rx_byte
    // Result stream.
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    // [31:0] src_id, [63:32] dst_id, [71:64] payload_length,
    // [79:72] byte_index, [87:80] payload_byte, [95:88] zero
    output logic [shfd_pkg::TDATA_W-1:0]             m_tdata,
    output logic [shfd_pkg::TUSER_W-1:0]             m_tuser,  // [0] byte_valid, [1] overflow
    output logic                                     m_tlast
);

    // Configuration registers.
    logic [2:0]  id_bytes_reg;
    logic [31:0] default_dest_reg;
    logic [31:0] default_orig_reg;

    // Parser state. The parser is in a frame whenever pos_reg is not zero.
    logic [8:0]  pos_reg,       pos_next;
    logic [7:0]  frame_len_reg, frame_len_next;
    logic [31:0] dest_acc_reg,  dest_acc_next;

    // Output register and skid register.
    shfd_pkg::result_t out_reg,  out_next;
    logic              out_valid_reg, out_valid_next;
    shfd_pkg::result_t skid_reg, skid_next;
    logic              skid_valid_reg, skid_valid_next;

    // Per-byte work.
    logic              accept;
    logic [2:0]        id_count;
    logic [8:0]        hdr_end;
    logic [8:0]        idx_full;
    logic              is_last;
    logic              res_valid;
    shfd_pkg::result_t res;
    logic [31:0]       dest_sel;
    logic              out_free;

    assign s_tready = !skid_valid_reg;
    assign accept   = s_tvalid && s_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            id_bytes_reg     <= shfd_pkg::MAX_ID_BYTES;
            default_dest_reg <= '0;
            default_orig_reg <= '0;
        end
        else if (cfg_wr_en)
        begin
            unique case (shfd_pkg::cfg_index_t'(cfg_index))
                shfd_pkg::CFG_ID_BYTES:     id_bytes_reg     <= cfg_wdata[2:0];
                shfd_pkg::CFG_DEFAULT_DEST: default_dest_reg <= cfg_wdata;
                shfd_pkg::CFG_DEFAULT_ORIG: default_orig_reg <= cfg_wdata;
                default:                    ;
            endcase
        end
    end

    // Parser: settings above four ID bytes behave as four.
    assign id_count = (id_bytes_reg > shfd_pkg::MAX_ID_BYTES) ? shfd_pkg::MAX_ID_BYTES
                                                              : id_bytes_reg;
    assign hdr_end  = 9'd2 + {6'd0, id_count};
    assign idx_full = pos_reg - 9'd3 - {6'd0, id_count};
    assign is_last  = ({1'b0, idx_full} + 10'd1) >= {2'd0, frame_len_reg};
    assign dest_sel = (id_count == 3'd0) ? default_dest_reg : dest_acc_reg;

    always_comb
    begin
        pos_next       = pos_reg;
        frame_len_next = frame_len_reg;
        dest_acc_next  = dest_acc_reg;
        res_valid      = 1'b0;

        res.src_id         = default_orig_reg;
        res.dst_id         = dest_sel;
        res.payload_length = frame_len_reg;
        res.byte_index     = idx_full[7:0];
        res.payload_byte   = s_tdata;
        res.byte_valid     = 1'b1;
        res.overflow       = idx_full[7:0] >= 8'(MAX_DATA);
        res.last           = is_last;

        if (accept)
        begin
            priority if (pos_reg == 9'd0)
            begin
                if (s_tdata == shfd_pkg::SYNC_FIRST)
                    pos_next = 9'd1;
            end
            else if (pos_reg == 9'd1)
            begin
                // A wrong second byte is not retried as a first sync byte.
                if (s_tdata == shfd_pkg::SYNC_SECOND)
                begin
                    pos_next      = 9'd2;
                    dest_acc_next = '0;
                end
                else
                    pos_next = 9'd0;
            end
            else if (pos_reg < hdr_end)
            begin
                dest_acc_next = {dest_acc_reg[23:0], s_tdata};
                pos_next      = pos_reg + 9'd1;
            end
            else if (pos_reg == hdr_end)
            begin
                frame_len_next = s_tdata;
                if (s_tdata == 8'd0)
                begin
                    // Empty frame: a single marker result.
                    res_valid          = 1'b1;
                    res.payload_length = 8'd0;
                    res.byte_index     = 8'd0;
                    res.payload_byte   = 8'd0;
                    res.byte_valid     = 1'b0;
                    res.overflow       = 1'b0;
                    res.last           = 1'b1;
                    pos_next           = 9'd0;
                end
                else
                    pos_next = pos_reg + 9'd1;
            end
            else
            begin
                res_valid = 1'b1;
                pos_next  = is_last ? 9'd0 : pos_reg + 9'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= '0;
            frame_len_reg <= '0;
            dest_acc_reg  <= '0;
        end
        else
        begin
            pos_reg       <= pos_next;
            frame_len_reg <= frame_len_next;
            dest_acc_reg  <= dest_acc_next;
        end
    end

    // Output side. The skid register only fills while the output register is
    // stalled, and it is drained into the output register first.
    assign out_free = !out_valid_reg || m_tready;

    always_comb
    begin
        out_next        = out_reg;
        out_valid_next  = out_valid_reg;
        skid_next       = skid_reg;
        skid_valid_next = skid_valid_reg;
        if (out_free)
        begin
            out_next        = skid_valid_reg ? skid_reg : res;
            out_valid_next  = skid_valid_reg || res_valid;
            skid_valid_next = 1'b0;
        end
        else if (res_valid)
        begin
            skid_next       = res;
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {8'd0, out_reg.payload_byte, out_reg.byte_index,
                       out_reg.payload_length, out_reg.dst_id, out_reg.src_id};
    assign m_tuser  = {out_reg.overflow, out_reg.byte_valid};
    assign m_tlast  = out_reg.last;

    // The skid register is only ever occupied behind a full output register.
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid register holds a result while output register is empty");

    // The final result of a frame always sends the parser back to the hunt.
    a_last_hunts: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res.last) |=> (pos_reg == 9'd0))
        else $error("parser did not return to hunt after last result");

    // An empty-frame marker is a lone, last result at index zero.
    a_empty_marker: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && !res.byte_valid) |-> (res.last && res.byte_index == 8'd0))
        else $error("malformed empty-frame marker");

    // Overflow is only flagged on results that carry a payload byte.
    a_overflow_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser[1]) |-> m_tuser[0])
        else $error("overflow flagged on an empty-frame marker");

    // No result comes from a byte taken while hunting or during the sync pair.
    a_no_result_in_sync: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && pos_reg < 9'd2) |-> !res_valid)
        else $error("result produced during sync hunt");

endmodule

`default_nettype wire

// ----- test/tb_top.sv -----
// Self-checking testbench for the sync-header frame deframer: a directed table
// followed by random framed traffic, checked against an in-bench predictor.
// Depends on shfd_pkg and sync_header_frame_deframer from the RTL.

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    // The directed table mixes byte requests and register writes.
    typedef enum logic {ROW_BYTE, ROW_WRITE} row_kind_t;

    // One row: for a byte row, value[7:0] is the received byte; for a write row,
    // reg_idx/value form the register write. When typed is set the row causes a
    // result whose value is spelled out in full in exp.
    typedef struct packed {
        row_kind_t            kind;
        shfd_pkg::cfg_index_t reg_idx;
        logic [31:0]          value;
        logic                 typed;
        shfd_pkg::result_t    exp;
    } stim_row_t;

    localparam int DIRECTED_ROWS = 29;
    localparam int RANDOM_BYTES  = 1300;

    logic                          clk       = 1'b0;
    logic                          rst_n     = 1'b0;
    logic                          cfg_wr_en = 1'b0;
    shfd_pkg::cfg_index_t          cfg_index = shfd_pkg::CFG_ID_BYTES;
    logic [31:0]                   cfg_wdata = '0;
    logic                          s_tvalid  = 1'b0;
    logic                          s_tready;
    logic [7:0]                    s_tdata   = '0;
    logic                          m_tvalid;
    logic                          m_tready  = 1'b1;
    logic [shfd_pkg::TDATA_W-1:0]  m_tdata;
    logic [shfd_pkg::TUSER_W-1:0]  m_tuser;
    logic                          m_tlast;

    sync_header_frame_deframer dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    always #5 clk = ~clk;

    // Run limit: a run that has not finished in time is reported as a fail.
    initial
    begin
        #2_000_000;
        $display("sync_header_frame_deframer regression: fail");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Predictor state: a shadow of the three registers and of the parser.
    // ------------------------------------------------------------------------
    logic [2:0]  shadow_id_bytes = shfd_pkg::MAX_ID_BYTES;
    logic [31:0] shadow_dest_id  = '0;
    logic [31:0] shadow_orig_id  = '0;
    logic [8:0]  parse_pos       = '0;   // 0 while hunting for the sync pair
    logic [7:0]  frame_len       = '0;   // kept after the frame, may go stale
    logic [31:0] dest_acc        = '0;

    shfd_pkg::result_t expected_results[$];
    int                mismatches = 0;
    bit                no_gaps    = 1'b0;

    // Settings above the largest ID count behave as the largest ID count.
    function automatic int unsigned id_count();
        return (shadow_id_bytes > shfd_pkg::MAX_ID_BYTES) ? int'(shfd_pkg::MAX_ID_BYTES)
                                                          : int'(shadow_id_bytes);
    endfunction

    function automatic shfd_pkg::result_t frame_result(logic [8:0] idx, logic [7:0] data,
                                                       logic valid, logic fin);
        shfd_pkg::result_t r;
        r.src_id         = shadow_orig_id;
        r.dst_id         = (id_count() == 0) ? shadow_dest_id : dest_acc;
        r.payload_length = frame_len;
        r.byte_index     = idx[7:0];
        r.payload_byte   = data;
        r.byte_valid     = valid;
        r.overflow       = valid && (idx[7:0] >= shfd_pkg::MAX_DATA);
        r.last           = fin;
        return r;
    endfunction

    // Advances the parser by one received byte. Returns 1 when the byte makes
    // a result, which is then placed in r.
    function automatic bit deframe_step(input logic [7:0] b,
                                        output shfd_pkg::result_t r);
        int unsigned n;
        logic [8:0]  idx;
        bit          fin;
        n = id_count();
        r = '0;
        if (parse_pos == 0)
        begin
            if (b == shfd_pkg::SYNC_FIRST)
                parse_pos = 9'd1;
            return 1'b0;
        end
        // A bad second byte drops back to the hunt and is not looked at again.
        if (parse_pos == 1)
        begin
            if (b == shfd_pkg::SYNC_SECOND)
            begin
                parse_pos = 9'd2;
                dest_acc  = '0;
            end
            else
                parse_pos = '0;
            return 1'b0;
        end
        if (parse_pos < 2 + n)
        begin
            dest_acc  = {dest_acc[23:0], b};
            parse_pos = parse_pos + 9'd1;
            return 1'b0;
        end
        if (parse_pos == 2 + n)
        begin
            frame_len = b;
            if (b == 8'd0)
            begin
                r         = frame_result(9'd0, 8'd0, 1'b0, 1'b1);
                parse_pos = '0;
                return 1'b1;
            end
            parse_pos = parse_pos + 9'd1;
            return 1'b0;
        end
        // Payload. The ID count is read afresh each byte, so a register write
        // in the middle of a frame shifts where the payload is taken to start.
        idx       = parse_pos - 9'd3 - 9'(n);
        fin       = (10'(idx) + 10'd1) >= 10'(frame_len);
        r         = frame_result(idx, b, 1'b1, fin);
        parse_pos = fin ? 9'd0 : parse_pos + 9'd1;
        return 1'b1;
    endfunction

    // ------------------------------------------------------------------------
    // Handshake helpers. Inputs move on the falling edge only.
    // ------------------------------------------------------------------------
    function automatic bit take_gap();
        return !no_gaps && ($urandom_range(0, 99) < 8);
    endfunction

    // The receiver stalls now and then, except during the quiet stretch.
    always @(negedge clk)
        m_tready <= !take_gap();

    // Offers one byte, holding it until the request is taken, then runs the
    // predictor. A typed expectation replaces the predicted one.
    task automatic push_rx_byte(logic [7:0] b, bit typed, shfd_pkg::result_t typed_res);
        shfd_pkg::result_t r;
        bit                has;
        @(negedge clk);
        while (take_gap())
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        has = deframe_step(b, r);
        if (typed)
            expected_results.push_back(typed_res);
        else if (has)
            expected_results.push_back(r);
    endtask

    // Register writes happen only with the stream quiet. A byte without a
    // result may still be in the parser, so the task still waits after the
    // last expected result before the write goes out.
    task automatic write_reg(shfd_pkg::cfg_index_t idx, logic [31:0] val);
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        case (idx)
            shfd_pkg::CFG_ID_BYTES:     shadow_id_bytes = val[2:0];
            shfd_pkg::CFG_DEFAULT_DEST: shadow_dest_id  = val;
            shfd_pkg::CFG_DEFAULT_ORIG: shadow_orig_id  = val;
            default:                    ;
        endcase
    endtask

    function automatic logic [31:0] pick_id();
        case ($urandom_range(0, 3))
            0:       return '0;
            1:       return '1;
            default: return $urandom;
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Result checking: every accepted result against the oldest expectation.
    // ------------------------------------------------------------------------
    function automatic void compare_field(string what, logic [31:0] want, logic [31:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch: expected %h, actual %h", $time, what, want, got);
            mismatches++;
        end
    endfunction

    always @(posedge clk)
    begin : result_check
        shfd_pkg::result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_results.size() == 0)
            begin
                $display("%0t: unexpected result: expected none, %s %h tuser %b tlast %b",
                         $time, "actual tdata", m_tdata, m_tuser, m_tlast);
                mismatches++;
            end
            else
            begin
                want = expected_results.pop_front();
                compare_field("src_id",         want.src_id,         m_tdata[31:0]);
                compare_field("dst_id",         want.dst_id,         m_tdata[63:32]);
                compare_field("payload_length", want.payload_length, m_tdata[71:64]);
                compare_field("byte_index",     want.byte_index,     m_tdata[79:72]);
                compare_field("payload_byte",   want.payload_byte,   m_tdata[87:80]);
                compare_field("tdata padding",  32'd0,               m_tdata[95:88]);
                compare_field("byte_valid",     want.byte_valid,     m_tuser[0]);
                compare_field("overflow",       want.overflow,       m_tuser[1]);
                compare_field("last",           want.last,           m_tlast);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Directed table. It starts from the reset register values (four ID bytes,
    // both default IDs zero), so an empty frame and a short frame there show
    // whether reset loaded them. Noise, a doubled first sync byte and a stray
    // second sync byte come first; the second 0x55 must not open a new sync pair.
    // The ID bytes use all-ones and all-zeros bytes. Then the ID count goes to
    // zero with both default IDs at all ones, and finally to seven, which must
    // behave as four for the random traffic that follows.
    // ------------------------------------------------------------------------
    stim_row_t directed_rows [DIRECTED_ROWS] = '{
        '{ROW_BYTE, shfd_pkg::CFG_UNUSED, 32'h00, 1'b0, '0},
        '{ROW_BYTE, shfd_pkg::CFG_UNUSED, 32'hFF, 1'b0, '0},
        '{ROW_BYTE, shfd_pkg::CFG_UNUSED, 32'h55, 1'b0, '0},
        '{ROW_BYTE, shfd_pkg::CFG_UNUSED, 32'h55, 1'b0, '0},
        '{ROW_BYTE, shfd_pkg::CFG_UNUSED, 32'hAA, 1'b0, '0},
        '{ROW_BYTE, shfd_pkg::CFG_UNUSED, 32'h55, 1'b0, '0},
        '{ROW_BYTE, shfd_pkg::CFG_UNUSED, 32'hAA, 1'b0, '0},
        '{ROW_BYTE, shfd_pkg::CFG_UNUSED, 32'hFF, 1'b0, '0},
        '{ROW_BYTE, shfd_pkg::CFG_UNUSED, 32'h00, 1'b0, '0},
        '{ROW_BYTE, shfd_pkg::CFG_UNUSED, 32'h12, 1'b0, '0},
        '{ROW_BYTE, shfd_pkg::CFG_UNUSED, 32'h80, 1'b0, '0},
        // Zero length: one empty result marked last.
        '{ROW_BYTE, shfd_pkg::CFG_UNUSED, 32'h00, 1'b1,
          '{32'h0, 32'hFF00_1280, 8'd0, 8'd0, 8'h00, 1'b0, 1'b0, 1'b1}},
        '{ROW_BYTE, shfd_pkg::CFG_UNUSED, 32'h55, 1'b0, '0},
        '{ROW_BYTE, shfd_pkg::CFG_UNUSED, 32'hAA, 1'b0, '0},
        '{ROW_BYTE, shfd_pkg::CFG_UNUSED, 32'h01, 1'b0, '0},
        '{ROW_BYTE, shfd_pkg::CFG_UNUSED, 32'h02, 1'b0, '0},
        '{ROW_BYTE, shfd_pkg::CFG_UNUSED, 32'h03, 1'b0, '0},
        '{ROW_BYTE, shfd_pkg::CFG_UNUSED, 32'h04, 1'b0, '0},
        '{ROW_BYTE, shfd_pkg::CFG_UNUSED, 32'h02, 1'b0, '0},
        '{ROW_BYTE, shfd_pkg::CFG_UNUSED, 32'hFF, 1'b1,
          '{32'h0, 32'h0102_0304, 8'd2, 8'd0, 8'hFF, 1'b1, 1'b0, 1'b0}},
        '{ROW_BYTE, shfd_pkg::CFG_UNUSED, 32'h00, 1'b1,
          '{32'h0, 32'h0102_0304, 8'd2, 8'd1, 8'h00, 1'b1, 1'b0, 1'b1}},
        '{ROW_WRITE, shfd_pkg::CFG_ID_BYTES,     32'd0,         1'b0, '0},
        '{ROW_WRITE, shfd_pkg::CFG_DEFAULT_DEST, 32'hFFFF_FFFF, 1'b0, '0},
        '{ROW_WRITE, shfd_pkg::CFG_DEFAULT_ORIG, 32'hFFFF_FFFF, 1'b0, '0},
        // No ID bytes: the length follows the sync pair directly.
        '{ROW_BYTE, shfd_pkg::CFG_UNUSED, 32'h55, 1'b0, '0},
        '{ROW_BYTE, shfd_pkg::CFG_UNUSED, 32'hAA, 1'b0, '0},
        '{ROW_BYTE, shfd_pkg::CFG_UNUSED, 32'h01, 1'b0, '0},
        '{ROW_BYTE, shfd_pkg::CFG_UNUSED, 32'h5A, 1'b1,
          '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'd1, 8'd0, 8'h5A, 1'b1, 1'b0, 1'b1}},
        '{ROW_WRITE, shfd_pkg::CFG_ID_BYTES, 32'd7, 1'b0, '0}
    };

    // ------------------------------------------------------------------------
    // Stimulus: reset, the directed table, then random frames.
    // ------------------------------------------------------------------------
    initial
    begin : stimulus
        int unsigned framed;      // bytes sent inside well-formed frames
        int unsigned since_write; // framed bytes since the last register phase
        int unsigned phase;
        int unsigned sel;
        logic [7:0]  len;
        logic [7:0]  b;
        bit          max_len_sent;

        framed       = 0;
        since_write  = 0;
        phase        = 0;
        max_len_sent = 1'b0;

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (directed_rows[i])
        begin
            if (directed_rows[i].kind == ROW_WRITE)
                write_reg(directed_rows[i].reg_idx, directed_rows[i].value);
            else
                push_rx_byte(directed_rows[i].value[7:0], directed_rows[i].typed,
                             directed_rows[i].exp);
        end

        while (framed < RANDOM_BYTES)
        begin
            // Register phase. Half the time a frame is left open first, so the
            // new ID count lands in the middle of a header or a payload.
            if (since_write >= 100)
            begin
                if ($urandom_range(0, 1))
                begin
                    push_rx_byte(shfd_pkg::SYNC_FIRST, 1'b0, '0);
                    push_rx_byte(shfd_pkg::SYNC_SECOND, 1'b0, '0);
                    repeat ($urandom_range(0, 3))
                        push_rx_byte(8'($urandom_range(0, 255)), 1'b0, '0);
                end
                write_reg(shfd_pkg::CFG_ID_BYTES,
                          (phase < 8) ? 32'(phase) : 32'($urandom_range(0, 7)));
                write_reg(shfd_pkg::CFG_DEFAULT_DEST, pick_id());
                write_reg(shfd_pkg::CFG_DEFAULT_ORIG, pick_id());
                if (phase % 4 == 3)
                    write_reg(shfd_pkg::CFG_UNUSED, $urandom);
                phase++;
                since_write = 0;
            end

            // A stretch with no gaps on either side.
            no_gaps = (framed >= 500) && (framed < 800);

            // Line noise between frames now and then.
            if ($urandom_range(0, 3) == 0)
                repeat ($urandom_range(1, 3))
                    push_rx_byte(8'($urandom_range(0, 255)), 1'b0, '0);

            sel = $urandom_range(0, 99);
            if (sel < 80)
            begin
                // Well-formed frame with random ID and payload content. Most
                // lengths are short; some cross the overflow boundary.
                sel = $urandom_range(0, 199);
                if (sel < 20)
                    len = 8'd0;
                else if (sel < 190)
                    len = 8'($urandom_range(1, 12));
                else if (sel < 198)
                    len = 8'($urandom_range(shfd_pkg::MAX_DATA - 8, shfd_pkg::MAX_DATA + 8));
                else
                    len = 8'hFF;
                if (!max_len_sent && framed >= 1000)
                    len = 8'hFF;
                if (len == 8'hFF)
                    max_len_sent = 1'b1;
                push_rx_byte(shfd_pkg::SYNC_FIRST, 1'b0, '0);
                push_rx_byte(shfd_pkg::SYNC_SECOND, 1'b0, '0);
                repeat (id_count()) push_rx_byte(8'($urandom_range(0, 255)), 1'b0, '0);
                push_rx_byte(len, 1'b0, '0);
                repeat (len) push_rx_byte(8'($urandom_range(0, 255)), 1'b0, '0);
                framed      += 3 + id_count() + len;
                since_write += 3 + id_count() + len;
            end
            else if (sel < 92)
            begin
                // Broken sync pair; a second 0x55 is the interesting case.
                b = 8'($urandom_range(0, 255));
                if (b == shfd_pkg::SYNC_SECOND || $urandom_range(0, 2) == 0)
                    b = shfd_pkg::SYNC_FIRST;
                push_rx_byte(shfd_pkg::SYNC_FIRST, 1'b0, '0);
                push_rx_byte(b, 1'b0, '0);
            end
            else
            begin
                // Frame cut short; the next frame's bytes fall into it.
                push_rx_byte(shfd_pkg::SYNC_FIRST, 1'b0, '0);
                push_rx_byte(shfd_pkg::SYNC_SECOND, 1'b0, '0);
                repeat ($urandom_range(0, id_count() + 2))
                    push_rx_byte(8'($urandom_range(0, 255)), 1'b0, '0);
            end
        end

        // Drain: wait for every expected result, then keep the check running to
        // catch anything the block sends without a request behind it.
        no_gaps = 1'b0;
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);

        if (mismatches == 0)
            $display("sync_header_frame_deframer regression: pass");
        else
            $display("sync_header_frame_deframer regression: fail");
        $finish;
    end

endmodule
